// File: hw/rtl/sm3_compression_defines.svh
// ----------------------------------------------------------------------------
// sm3_compression_defines
// Assertion macros used by the SM3 compression checker.
// ----------------------------------------------------------------------------
`ifndef SM3_COMPRESSION_DEFINES_SVH
`define SM3_COMPRESSION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SM3_ASSERT_IMP(label, ante, cons, text) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(text);

// Next-cycle implication, sampled on clk, off during reset.
`define SM3_ASSERT_NEXT(label, ante, cons, text) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(text);

`endif

// File: hw/rtl/sm3c_pkg.sv
// ----------------------------------------------------------------------------
// sm3c_pkg
// Types, constants and round functions of the SM3 compression block.
// ----------------------------------------------------------------------------
package sm3c_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = 16;
    localparam int NUM_CHAIN   = 8;
    localparam int ROUNDS      = 64;
    localparam int XOR_ROUNDS  = 16;
    localparam int CNT_W       = $clog2(NUM_WORDS);
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int CFG_INDEX_W = 4;
    // power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] block_t;
    typedef word_t [NUM_CHAIN-1:0] chain_t;

    localparam chain_t IV_RESET = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    localparam word_t T_LOW     = 32'h79CC4519;
    // T_HIGH = 7A879D8A pre-rotated by 16 for the first high round
    localparam word_t T_HIGH_16 = 32'h9D8A7A87;

    typedef struct packed {
        block_t words;
        logic   restart;
        chain_t init;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } back_state_t;

    function automatic word_t rotl(input word_t v, input int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic word_t perm0(input word_t v);
        return v ^ rotl(v, 9) ^ rotl(v, 17);
    endfunction

    function automatic word_t perm1(input word_t v);
        return v ^ rotl(v, 15) ^ rotl(v, 23);
    endfunction

endpackage

// File: hw/rtl/sm3_word_if.sv
// ----------------------------------------------------------------------------
// sm3_word_if
// Message word channel: one 32-bit word and a restart flag per transaction.
// ----------------------------------------------------------------------------
interface sm3_word_if;
    logic           valid;
    logic           ready;
    sm3c_pkg::word_t msg_word;
    logic           restart;

    modport source (output valid, output msg_word, output restart, input ready);
    modport sink   (input valid, input msg_word, input restart, output ready);
endinterface

// File: hw/rtl/sm3_hash_if.sv
// ----------------------------------------------------------------------------
// sm3_hash_if
// Digest channel: eight chaining words per transaction.
// ----------------------------------------------------------------------------
interface sm3_hash_if;
    logic            valid;
    logic            ready;
    sm3c_pkg::word_t hash0;
    sm3c_pkg::word_t hash1;
    sm3c_pkg::word_t hash2;
    sm3c_pkg::word_t hash3;
    sm3c_pkg::word_t hash4;
    sm3c_pkg::word_t hash5;
    sm3c_pkg::word_t hash6;
    sm3c_pkg::word_t hash7;

    modport source (
        output valid, output hash0, output hash1, output hash2, output hash3,
        output hash4, output hash5, output hash6, output hash7, input ready
    );
    modport sink (
        input valid, input hash0, input hash1, input hash2, input hash3,
        input hash4, input hash5, input hash6, input hash7, output ready
    );
endinterface

// File: hw/rtl/sm3c_front.sv
// ----------------------------------------------------------------------------
// sm3c_front
// Collects message words into blocks, tracks restart and holds the
// initial-value registers; hands each full block to the job queue.
// ----------------------------------------------------------------------------
module sm3c_front (
    input  logic                              clk,
    input  logic                              rst_n,
    sm3_word_if.sink                          msg,
    input  logic                              cfg_wr_en,
    input  logic [sm3c_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  sm3c_pkg::word_t                   cfg_data,
    input  sm3c_pkg::queue_status_t           q_status,
    output logic                              push,
    output sm3c_pkg::job_t                    job
);

    sm3c_pkg::chain_t                  init_reg;
    sm3c_pkg::chain_t                  snap_reg;
    sm3c_pkg::block_t                  window_reg;
    logic [sm3c_pkg::CNT_W-1:0]        count_reg;
    logic                              restart_reg;

    logic [sm3c_pkg::CNT_W-1:0]        idx;
    logic                              last;
    logic                              accept;

    assign msg.ready = !((count_reg == sm3c_pkg::CNT_W'(sm3c_pkg::NUM_WORDS - 1))
                         && q_status.full);
    assign accept    = msg.valid && msg.ready;
    assign idx       = msg.restart ? '0 : count_reg;
    assign last      = (idx == sm3c_pkg::CNT_W'(sm3c_pkg::NUM_WORDS - 1));
    assign push      = accept && last;

    always_comb
    begin
        job.words = window_reg;
        job.words[sm3c_pkg::NUM_WORDS-1] = msg.msg_word;
        job.restart = restart_reg;
        job.init = snap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg    <= sm3c_pkg::IV_RESET;
            count_reg   <= '0;
            restart_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index < sm3c_pkg::CFG_INDEX_W'(sm3c_pkg::NUM_CHAIN)))
            begin
                init_reg[cfg_index[$clog2(sm3c_pkg::NUM_CHAIN)-1:0]] <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= idx + sm3c_pkg::CNT_W'(1);
                if (last)
                begin
                    restart_reg <= 1'b0;
                end
                else if (msg.restart)
                begin
                    restart_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg[idx] <= msg.msg_word;
            if (msg.restart)
            begin
                snap_reg <= init_reg;
            end
        end
    end

endmodule

// File: hw/rtl/sm3c_queue.sv
// ----------------------------------------------------------------------------
// sm3c_queue
// Short job queue between block collection and the round engine.
// ----------------------------------------------------------------------------
module sm3c_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sm3c_pkg::job_t          push_job,
    input  logic                    pop,
    output sm3c_pkg::job_t          pop_job,
    output sm3c_pkg::queue_status_t status
);

    sm3c_pkg::job_t               mem_reg [sm3c_pkg::QUEUE_DEPTH];
    logic [sm3c_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [sm3c_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [sm3c_pkg::QPTR_W:0]    fill_reg;

    assign status.full  = (fill_reg == (sm3c_pkg::QPTR_W+1)'(sm3c_pkg::QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign pop_job      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + sm3c_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sm3c_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (sm3c_pkg::QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (sm3c_pkg::QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/sm3c_back.sv
// ----------------------------------------------------------------------------
// sm3c_back
// Round engine: one SM3 round per cycle with on-the-fly message expansion,
// chaining-value update and a registered digest output.
// ----------------------------------------------------------------------------
module sm3c_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sm3c_pkg::job_t          job,
    input  sm3c_pkg::queue_status_t q_status,
    output logic                    pop,
    sm3_hash_if.source              digest
);

    sm3c_pkg::back_state_t          state_reg, state_next;
    logic [sm3c_pkg::ROUND_W-1:0]   round_reg, round_next;
    sm3c_pkg::block_t               w_reg, w_next;
    sm3c_pkg::chain_t               r_reg, r_next;
    sm3c_pkg::chain_t               v_reg, v_next;
    sm3c_pkg::word_t                t_reg, t_next;
    sm3c_pkg::chain_t               out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    sm3c_pkg::word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    sm3c_pkg::chain_t base;
    logic xor_round;

    assign digest.valid = out_valid_reg;
    assign digest.hash0 = out_reg[0];
    assign digest.hash1 = out_reg[1];
    assign digest.hash2 = out_reg[2];
    assign digest.hash3 = out_reg[3];
    assign digest.hash4 = out_reg[4];
    assign digest.hash5 = out_reg[5];
    assign digest.hash6 = out_reg[6];
    assign digest.hash7 = out_reg[7];

    always_comb
    begin
        xor_round = (round_reg < sm3c_pkg::ROUND_W'(sm3c_pkg::XOR_ROUNDS));
        a12 = sm3c_pkg::rotl(r_reg[0], 12);
        ss1 = sm3c_pkg::rotl(a12 + r_reg[4] + t_reg, 7);
        ss2 = ss1 ^ a12;
        if (xor_round)
        begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[0];
        w_new = sm3c_pkg::perm1(w_reg[0] ^ w_reg[7] ^ sm3c_pkg::rotl(w_reg[13], 15))
                ^ sm3c_pkg::rotl(w_reg[3], 7) ^ w_reg[10];
        base = job.restart ? job.init : v_reg;

        state_next     = state_reg;
        round_next     = round_reg;
        w_next         = w_reg;
        r_next         = r_reg;
        v_next         = v_reg;
        t_next         = t_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !digest.ready;
        pop            = 1'b0;

        unique case (state_reg)
            sm3c_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    v_next     = base;
                    r_next     = base;
                    w_next     = job.words;
                    t_next     = sm3c_pkg::T_LOW;
                    round_next = '0;
                    state_next = sm3c_pkg::ST_RUN;
                end
            end
            sm3c_pkg::ST_RUN:
            begin
                r_next[3] = r_reg[2];
                r_next[2] = sm3c_pkg::rotl(r_reg[1], 9);
                r_next[1] = r_reg[0];
                r_next[0] = tt1;
                r_next[7] = r_reg[6];
                r_next[6] = sm3c_pkg::rotl(r_reg[5], 19);
                r_next[5] = r_reg[4];
                r_next[4] = sm3c_pkg::perm0(tt2);
                w_next = {w_new, w_reg[sm3c_pkg::NUM_WORDS-1:1]};
                if (round_reg == sm3c_pkg::ROUND_W'(sm3c_pkg::XOR_ROUNDS - 1))
                begin
                    t_next = sm3c_pkg::T_HIGH_16;
                end
                else
                begin
                    t_next = sm3c_pkg::rotl(t_reg, 1);
                end
                round_next = round_reg + sm3c_pkg::ROUND_W'(1);
                if (round_reg == sm3c_pkg::ROUND_W'(sm3c_pkg::ROUNDS - 1))
                begin
                    state_next = sm3c_pkg::ST_FINISH;
                end
            end
            sm3c_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || digest.ready)
                begin
                    v_next         = v_reg ^ r_reg;
                    out_next       = v_reg ^ r_reg;
                    out_valid_next = 1'b1;
                    state_next     = sm3c_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sm3c_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sm3c_pkg::ST_IDLE;
            round_reg     <= '0;
            v_reg         <= sm3c_pkg::IV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        r_reg   <= r_next;
        t_reg   <= t_next;
        out_reg <= out_next;
    end

endmodule

// File: hw/rtl/sm3_compression.sv
// ----------------------------------------------------------------------------
// sm3_compression
// Path from the edge that takes a block's sixteenth word to digest valid:
//   dequeue, the SM3 rounds, then the chaining update, which waits while an earlier digest is stalled.
// Block rate is set by the single-round datapath; words are taken one per
//   cycle into a 2-deep block queue, except that the last word of a block
//   stalls while that queue is full. Reset: init registers and chaining
//   value to the SM3 IV, word count and queue cleared, no digest pending.
// ----------------------------------------------------------------------------
module sm3_compression (
    input  logic                              clk,
    input  logic                              rst_n,
    sm3_word_if.sink                          msg,
    sm3_hash_if.source                        digest,
    input  logic                              cfg_wr_en,
    input  logic [sm3c_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  sm3c_pkg::word_t                   cfg_data
);

    sm3c_pkg::queue_status_t q_status;
    sm3c_pkg::job_t          push_job;
    sm3c_pkg::job_t          pop_job;
    logic                    push;
    logic                    pop;

    sm3c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .job       (push_job)
    );

    sm3c_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    sm3c_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (pop_job),
        .q_status (q_status),
        .pop      (pop),
        .digest   (digest)
    );

endmodule

// File: hw/rtl/sm3_compression_checker.sv
// ----------------------------------------------------------------------------
// sm3_compression_checker
// Port-level checks: digest hold under stall, no digest without a
// completed block, input open once all blocks are delivered.
// ----------------------------------------------------------------------------
`include "sm3_compression_defines.svh"

module sm3_compression_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            msg_valid,
    input logic            msg_ready,
    input logic            msg_restart,
    input logic            digest_valid,
    input logic            digest_ready,
    input sm3c_pkg::word_t digest_hash0,
    input sm3c_pkg::word_t digest_hash7
);

    logic [sm3c_pkg::CNT_W-1:0] count_reg;
    logic [3:0]                 pending_reg;
    logic [sm3c_pkg::CNT_W-1:0] idx;
    logic                       word_xfer;
    logic                       block_done;
    logic                       digest_xfer;

    assign word_xfer   = msg_valid && msg_ready;
    assign idx         = msg_restart ? '0 : count_reg;
    assign block_done  = word_xfer && (idx == sm3c_pkg::CNT_W'(sm3c_pkg::NUM_WORDS - 1));
    assign digest_xfer = digest_valid && digest_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (word_xfer)
            begin
                count_reg <= idx + sm3c_pkg::CNT_W'(1);
            end
            if (block_done && !digest_xfer)
            begin
                pending_reg <= pending_reg + 4'd1;
            end
            else if (digest_xfer && !block_done)
            begin
                pending_reg <= pending_reg - 4'd1;
            end
        end
    end

    `SM3_ASSERT_NEXT(a_digest_hold, digest_valid && !digest_ready, digest_valid && $stable(digest_hash0) && $stable(digest_hash7), "digest changed or dropped while stalled")
    `SM3_ASSERT_IMP(a_digest_has_block, digest_valid, pending_reg != 4'd0, "digest without a completed block")
    `SM3_ASSERT_IMP(a_ready_when_drained, pending_reg == 4'd0, msg_ready, "input stalled with no block in flight")

endmodule

bind sm3_compression sm3_compression_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg.valid),
    .msg_ready    (msg.ready),
    .msg_restart  (msg.restart),
    .digest_valid (digest.valid),
    .digest_ready (digest.ready),
    .digest_hash0 (digest.hash0),
    .digest_hash7 (digest.hash7)
);

// File: tb/sm3_compression_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sm3_compression_tb
// Drives message words into the SM3 compression block, predicts every
// chaining update with an in-bench SM3 compression, and compares each digest
// transaction word by word. Covers restarts, chaining without restart,
// discarded partial blocks, init register writes and random back-pressure.
// ----------------------------------------------------------------------------
module sm3_compression_tb;

    localparam int              CYCLE_LIMIT   = 200000;
    localparam int              DRAIN_CYCLES  = 80;
    localparam int              IDLE_PCT      = 35;
    localparam int              REG_INIT_BASE = 0;
    localparam int              NUM_CFG_SLOTS = 2 ** sm3c_pkg::CFG_INDEX_W;
    localparam sm3c_pkg::word_t ROUND_T_LOW   = 32'h79CC4519;
    localparam sm3c_pkg::word_t ROUND_T_HIGH  = 32'h7A879D8A;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [sm3c_pkg::CFG_INDEX_W-1:0] cfg_index;
    sm3c_pkg::word_t                  cfg_data;

    sm3_word_if msg_if ();
    sm3_hash_if hash_if ();

    sm3_compression u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_if),
        .digest    (hash_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // predictor state
    sm3c_pkg::word_t  init_words [sm3c_pkg::NUM_CHAIN];
    sm3c_pkg::chain_t chain_state;
    sm3c_pkg::word_t  block_words [sm3c_pkg::NUM_WORDS];
    int unsigned      words_taken;
    sm3c_pkg::chain_t digest_q [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          stall_en       = 1'b1;

    function automatic sm3c_pkg::word_t rot_left(input sm3c_pkg::word_t v,
                                                 input int unsigned s);
        int unsigned k;
        k = s % sm3c_pkg::WORD_W;
        if (k == 0)
            return v;
        return (v << k) | (v >> (sm3c_pkg::WORD_W - k));
    endfunction

    function automatic sm3c_pkg::word_t mix_p0(input sm3c_pkg::word_t v);
        return v ^ rot_left(v, 9) ^ rot_left(v, 17);
    endfunction

    function automatic sm3c_pkg::word_t mix_p1(input sm3c_pkg::word_t v);
        return v ^ rot_left(v, 15) ^ rot_left(v, 23);
    endfunction

    function automatic sm3c_pkg::chain_t compress_block(
        input sm3c_pkg::chain_t cv,
        input sm3c_pkg::word_t  blk [sm3c_pkg::NUM_WORDS]
    );
        sm3c_pkg::word_t  wx [68];
        sm3c_pkg::word_t  wq [64];
        sm3c_pkg::word_t  r [sm3c_pkg::NUM_CHAIN];
        sm3c_pkg::word_t  a12, ss1, ss2, ff, gg, tt1, tt2, tj;
        sm3c_pkg::chain_t res;
        for (int j = 0; j < 16; j++)
            wx[j] = blk[j];
        for (int j = 16; j < 68; j++)
            wx[j] = mix_p1(wx[j-16] ^ wx[j-9] ^ rot_left(wx[j-3], 15))
                    ^ rot_left(wx[j-13], 7) ^ wx[j-6];
        for (int j = 0; j < 64; j++)
            wq[j] = wx[j] ^ wx[j+4];
        for (int j = 0; j < sm3c_pkg::NUM_CHAIN; j++)
            r[j] = cv[j];
        for (int j = 0; j < sm3c_pkg::ROUNDS; j++)
        begin
            tj  = (j < sm3c_pkg::XOR_ROUNDS) ? rot_left(ROUND_T_LOW, j)
                                             : rot_left(ROUND_T_HIGH, j);
            a12 = rot_left(r[0], 12);
            ss1 = rot_left(a12 + r[4] + tj, 7);
            ss2 = ss1 ^ a12;
            if (j < sm3c_pkg::XOR_ROUNDS)
            begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end
            else
            begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1  = ff + r[3] + ss2 + wq[j];
            tt2  = gg + r[7] + ss1 + wx[j];
            r[3] = r[2];
            r[2] = rot_left(r[1], 9);
            r[1] = r[0];
            r[0] = tt1;
            r[7] = r[6];
            r[6] = rot_left(r[5], 19);
            r[5] = r[4];
            r[4] = mix_p0(tt2);
        end
        for (int j = 0; j < sm3c_pkg::NUM_CHAIN; j++)
            res[j] = cv[j] ^ r[j];
        return res;
    endfunction

    function automatic void predict_word(input sm3c_pkg::word_t wd, input logic rs);
        if (rs)
        begin
            for (int i = 0; i < sm3c_pkg::NUM_CHAIN; i++)
                chain_state[i] = init_words[i];
            words_taken = 0;
        end
        block_words[words_taken] = wd;
        words_taken = (words_taken + 1) % sm3c_pkg::NUM_WORDS;
        if (words_taken == 0)
        begin
            chain_state = compress_block(chain_state, block_words);
            digest_q.push_back(chain_state);
        end
    endfunction

    function automatic sm3c_pkg::word_t rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return '1;
        if (pick < 24)
            return sm3c_pkg::word_t'(1) << $urandom_range(0, sm3c_pkg::WORD_W - 1);
        return $urandom;
    endfunction

    function automatic sm3c_pkg::word_t rand_reg_value();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    always @(posedge clk)
    begin
        hash_if.ready <= stall_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge clk)
    begin : digest_check
        sm3c_pkg::chain_t got;
        sm3c_pkg::chain_t want;
        if (rst_n && hash_if.valid && hash_if.ready)
        begin
            got = {hash_if.hash7, hash_if.hash6, hash_if.hash5, hash_if.hash4,
                   hash_if.hash3, hash_if.hash2, hash_if.hash1, hash_if.hash0};
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest transaction: %h", got);
                mismatch_count++;
            end
            else
            begin
                want = digest_q.pop_front();
                for (int i = 0; i < sm3c_pkg::NUM_CHAIN; i++)
                    if (got[i] !== want[i])
                    begin
                        $error("hash%0d: expected %08h, actual %08h", i, want[i], got[i]);
                        mismatch_count++;
                    end
            end
        end
    end

    task automatic send_word(input sm3c_pkg::word_t wd, input logic rs);
        while (stall_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
        end
        msg_if.valid    <= 1'b1;
        msg_if.msg_word <= wd;
        msg_if.restart  <= rs;
        do
            @(posedge clk);
        while (!msg_if.ready);
        predict_word(wd, rs);
    endtask

    task automatic send_words(input logic first_restart, input int unsigned n_words);
        for (int unsigned k = 0; k < n_words; k++)
            send_word(rand_word(), (k == 0) ? first_restart : 1'b0);
    endtask

    // stop sending, let every pending digest arrive and the datapath settle
    task automatic wait_idle();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int unsigned idx, input sm3c_pkg::word_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= sm3c_pkg::CFG_INDEX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        if (idx < REG_INIT_BASE + sm3c_pkg::NUM_CHAIN)
            init_words[idx - REG_INIT_BASE] = val;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_init(input sm3c_pkg::word_t val);
        for (int i = 0; i < sm3c_pkg::NUM_CHAIN; i++)
            write_reg(REG_INIT_BASE + i, val);
    endtask

    task automatic test_known_block();
        send_word(32'h61626380, 1'b1);
        for (int k = 1; k < sm3c_pkg::NUM_WORDS - 1; k++)
            send_word('0, 1'b0);
        send_word(32'h00000018, 1'b0);
    endtask

    task automatic test_chained_block();
        for (int k = 0; k < sm3c_pkg::NUM_WORDS; k++)
            send_word('1, 1'b0);
    endtask

    task automatic test_midblock_restart();
        send_words(1'b1, 3);
        send_word(32'h80000000, 1'b1);
        for (int k = 1; k < sm3c_pkg::NUM_WORDS; k++)
            send_word(sm3c_pkg::word_t'(1) << k, 1'b0);
    endtask

    task automatic test_register_writes();
        wait_idle();
        write_all_init('0);
        write_reg(REG_INIT_BASE + sm3c_pkg::NUM_CHAIN, $urandom);
        write_reg(NUM_CFG_SLOTS - 1, $urandom);
        send_words(1'b1, 4);
        // new values must wait for the next restart
        wait_idle();
        write_all_init('1);
        send_words(1'b0, sm3c_pkg::NUM_WORDS - 4);
        send_words(1'b1, sm3c_pkg::NUM_WORDS);
        wait_idle();
    endtask

    task automatic run_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        int unsigned blocks;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                len = $urandom_range(1, sm3c_pkg::NUM_WORDS - 1);
                send_words(1'b1, len);
                sent += len;
            end
            else if (pick < 15)
            begin
                send_words(1'b0, sm3c_pkg::NUM_WORDS);
                sent += sm3c_pkg::NUM_WORDS;
            end
            else
            begin
                blocks = $urandom_range(1, 3);
                send_words(1'b1, sm3c_pkg::NUM_WORDS);
                for (int unsigned b = 1; b < blocks; b++)
                    send_words(1'b0, sm3c_pkg::NUM_WORDS);
                sent += blocks * sm3c_pkg::NUM_WORDS;
            end
        end
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            for (int i = 0; i < sm3c_pkg::NUM_CHAIN; i++)
                write_reg(REG_INIT_BASE + i,
                          (phase == 0) ? sm3c_pkg::IV_RESET[i] : rand_reg_value());
            write_reg($urandom_range(REG_INIT_BASE + sm3c_pkg::NUM_CHAIN, NUM_CFG_SLOTS - 1),
                      $urandom);
            stall_en = (phase != 2);
            run_random_traffic(370);
        end
        stall_en = 1'b1;
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        msg_if.valid    <= 1'b0;
        msg_if.msg_word <= '0;
        msg_if.restart  <= 1'b0;
        for (int i = 0; i < sm3c_pkg::NUM_CHAIN; i++)
        begin
            init_words[i]  = sm3c_pkg::IV_RESET[i];
            chain_state[i] = sm3c_pkg::IV_RESET[i];
        end
        for (int i = 0; i < sm3c_pkg::NUM_WORDS; i++)
            block_words[i] = '0;
        words_taken = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_known_block();
        test_chained_block();
        test_midblock_restart();
        test_register_writes();
        test_random_phases();

        wait_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sm3c_pkg.sv
hw/rtl/sm3_word_if.sv
hw/rtl/sm3_hash_if.sv
hw/rtl/sm3c_front.sv
hw/rtl/sm3c_queue.sv
hw/rtl/sm3c_back.sv
hw/rtl/sm3_compression.sv
hw/rtl/sm3_compression_checker.sv
tb/sm3_compression_tb.sv
